// ===== sv/bopa_pkg.sv =====
// Shared constants, codes and transaction types of the binary output priority array.
package bopa_pkg;

    localparam int NUM_OUTPUTS = 4;
    localparam int NUM_LEVELS  = 16;

    localparam int OBJ_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int LVL_W = $clog2(NUM_LEVELS);

    localparam logic [7:0] RESERVED_PRIORITY = 8'd6;
    localparam logic [7:0] VALUE_NULL        = 8'd255;

    localparam logic [2:0] KIND_COMMAND = 3'd0;
    localparam logic [2:0] KIND_SLOT    = 3'd1;
    localparam logic [2:0] KIND_DEFAULT = 3'd2;
    localparam logic [2:0] KIND_SERVICE = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_UNKNOWN   = 3'd1;
    localparam logic [2:0] STATUS_DENIED    = 3'd2;
    localparam logic [2:0] STATUS_RANGE     = 3'd3;
    localparam logic [2:0] STATUS_BAD_INDEX = 3'd4;

    localparam logic [1:0] SLOT_INACTIVE = 2'd0;
    localparam logic [1:0] SLOT_NULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [21:0] instance_req;
        logic [7:0]  priority_req;
        logic [7:0]  value;
        logic        is_null;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       resolved_value;
        logic       default_value;
        logic       service_off;
        logic [1:0] slot_value;
    } result_t;

endpackage

// ===== sv/binary_output_priority_array.sv =====
// Top level of the binary output priority array.
// Usage:
// A request transaction (kind, instance_req, priority_req, value, is_null) is
// accepted on a rising edge with in_valid high and in_stall low. Every request
// gives exactly one response transaction (status, resolved_value, default_value,
// service_off, slot_value), taken on an edge with out_valid high and out_stall low.
// The request is registered, then the engine updates the addressed instance and
// resolves its present value combinationally into the result register. One
// transaction per cycle is sustained while the receiver does not stall; the
// update plus 16-way priority encode is combinational.
// When the receiver stalls, the result register holds its transaction and the
// request register fills, after which in_stall rises.
// Reset clears every priority slot to null, every default to inactive, every
// out-of-service flag and active_count; no clearing pass follows, so requests
// are accepted right after reset. The user writes active_count through cfg_wr_en
// and cfg_wr_data only while no transaction is in flight; no logic enforces it.
module binary_output_priority_array (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [21:0] instance_req,
    input  logic [7:0]  priority_req,
    input  logic [7:0]  value,
    input  logic        is_null,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        resolved_value,
    output logic        default_value,
    output logic        service_off,
    output logic [1:0]  slot_value
);
    import bopa_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    load;
    result_t result;
    result_t out_result;

    assign in_item.kind         = kind;
    assign in_item.instance_req = instance_req;
    assign in_item.priority_req = priority_req;
    assign in_item.value        = value;
    assign in_item.is_null      = is_null;

    bopa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (load),
        .item_valid (item_valid),
        .item       (item)
    );

    bopa_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .commit      (load),
        .item        (item),
        .result      (result)
    );

    bopa_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_req   (item_valid),
        .result     (result),
        .load       (load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign status         = out_result.status;
    assign resolved_value = out_result.resolved_value;
    assign default_value  = out_result.default_value;
    assign service_off    = out_result.service_off;
    assign slot_value     = out_result.slot_value;

endmodule

// ===== sv/bopa_in_stage.sv =====
// Input register stage that holds one request transaction for the engine.
module bopa_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bopa_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output bopa_pkg::item_t item
);
    import bopa_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage refills whenever its content moves on or it is empty.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/bopa_engine.sv =====
// Per-instance priority arrays, defaults and flags, with the update and resolve logic.
module bopa_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_data,
    input  logic              commit,
    input  bopa_pkg::item_t   item,
    output bopa_pkg::result_t result
);
    import bopa_pkg::*;

    logic [2:0]       active_count_reg;
    logic [1:0]       level_reg [NUM_OUTPUTS][NUM_LEVELS];
    logic             fallback_reg [NUM_OUTPUTS];
    logic             service_reg [NUM_OUTPUTS];

    logic             inst_ok;
    logic             prio_ok;
    logic [21:0]      inst_m1;
    logic [7:0]       prio_m1;
    logic [OBJ_W-1:0] obj;
    logic [LVL_W-1:0] lvl;
    logic             value_bit_ok;
    logic             level_we;
    logic [1:0]       level_data;
    logic             fallback_we;
    logic             service_we;
    logic [2:0]       status;
    logic [1:0]       new_row [NUM_LEVELS];
    logic             fallback_new;
    logic             service_new;
    logic             present;

    assign inst_m1      = item.instance_req - 22'd1;
    assign prio_m1      = item.priority_req - 8'd1;
    assign obj          = inst_m1[OBJ_W-1:0];
    assign lvl          = prio_m1[LVL_W-1:0];
    assign value_bit_ok = (item.value <= 8'd1);

    // Counts above the number of instances behave as the full bank.
    assign inst_ok = (item.instance_req != 22'd0)
                  && (item.instance_req <= {19'd0, active_count_reg})
                  && (item.instance_req <= 22'(NUM_OUTPUTS));
    assign prio_ok = (item.priority_req != 8'd0)
                  && (item.priority_req <= 8'(NUM_LEVELS));

    always_comb
    begin
        level_we    = 1'b0;
        level_data  = SLOT_NULL;
        fallback_we = 1'b0;
        service_we  = 1'b0;
        status      = STATUS_OK;
        case (item.kind)
            KIND_COMMAND:
            begin
                if (item.is_null)
                begin
                    if (prio_ok)
                    begin
                        level_we = 1'b1;
                    end
                    else
                    begin
                        status = STATUS_RANGE;
                    end
                end
                else if (prio_ok && item.priority_req != RESERVED_PRIORITY && value_bit_ok)
                begin
                    level_we   = 1'b1;
                    level_data = {1'b0, item.value[0]};
                end
                else if (item.priority_req == RESERVED_PRIORITY)
                begin
                    status = STATUS_DENIED;
                end
                else
                begin
                    status = STATUS_RANGE;
                end
            end
            KIND_SLOT:
            begin
                if (!prio_ok)
                begin
                    status = STATUS_BAD_INDEX;
                end
                else if (item.is_null || item.value == VALUE_NULL)
                begin
                    level_we = 1'b1;
                end
                else if (value_bit_ok)
                begin
                    level_we   = 1'b1;
                    level_data = {1'b0, item.value[0]};
                end
                else
                begin
                    status = STATUS_RANGE;
                end
            end
            KIND_DEFAULT:
            begin
                if (!item.is_null && value_bit_ok)
                begin
                    fallback_we = 1'b1;
                end
                else
                begin
                    status = STATUS_RANGE;
                end
            end
            KIND_SERVICE:
            begin
                if (!item.is_null && value_bit_ok)
                begin
                    service_we = 1'b1;
                end
                else
                begin
                    status = STATUS_RANGE;
                end
            end
            KIND_QUERY:
            begin
                status = STATUS_OK;
            end
            default:
            begin
                status = STATUS_RANGE;
            end
        endcase
    end

    // The result reflects the state after this transaction's own write.
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            new_row[i] = level_reg[obj][i];
        end
        if (level_we)
        begin
            new_row[lvl] = level_data;
        end
        fallback_new = fallback_we ? item.value[0] : fallback_reg[obj];
        service_new  = service_we  ? item.value[0] : service_reg[obj];
        present = fallback_new;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (new_row[i] != SLOT_NULL)
            begin
                present = new_row[i][0];
            end
        end
    end

    always_comb
    begin
        if (!inst_ok)
        begin
            result.status         = STATUS_UNKNOWN;
            result.resolved_value = 1'b0;
            result.default_value  = 1'b0;
            result.service_off    = 1'b0;
            result.slot_value     = SLOT_NULL;
        end
        else
        begin
            result.status         = status;
            result.resolved_value = present;
            result.default_value  = fallback_new;
            result.service_off    = service_new;
            result.slot_value     = prio_ok ? new_row[lvl] : SLOT_NULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= 3'd0;
        end
        else if (cfg_wr_en)
        begin
            active_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < NUM_OUTPUTS; o++)
            begin
                for (int i = 0; i < NUM_LEVELS; i++)
                begin
                    level_reg[o][i] <= SLOT_NULL;
                end
                fallback_reg[o] <= SLOT_INACTIVE[0];
                service_reg[o]  <= 1'b0;
            end
        end
        else if (commit && inst_ok)
        begin
            if (level_we)
            begin
                level_reg[obj][lvl] <= level_data;
            end
            if (fallback_we)
            begin
                fallback_reg[obj] <= item.value[0];
            end
            if (service_we)
            begin
                service_reg[obj] <= item.value[0];
            end
        end
    end

endmodule

// ===== sv/bopa_out_stage.sv =====
// Result register that holds one response transaction until the receiver takes it.
module bopa_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_req,
    input  bopa_pkg::result_t result,
    output logic              load,
    output logic              out_valid,
    input  logic              out_stall,
    output bopa_pkg::result_t out_result
);
    import bopa_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The register takes a new result when it is empty or being emptied.
    assign load       = load_req && (!valid_reg || !out_stall);
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
